@@ hdl/szw_pkg.sv @@
// ----------------------------------------------------------------------------
// szw_pkg
// Shared types and constants for the scan zone nearest wall detector.
// ----------------------------------------------------------------------------
package szw_pkg;

  localparam int POINT_W = 16;
  localparam int WALL_W  = 16;
  localparam int ROAD_W  = 12;
  localparam int ROBOT_W = 11;
  localparam int CFG_IDX_W = 1;

  // signed working width for coordinate compares
  localparam int CRD_W = POINT_W + 2;
  // unsigned width of a zone distance (magnitude of a point coordinate)
  localparam int DIST_W = POINT_W + 1;

  localparam int NZONE           = 5;
  localparam int ZONE_FRONT      = 0;
  localparam int ZONE_LEFT       = 1;
  localparam int ZONE_LEFT_REAR  = 2;
  localparam int ZONE_RIGHT      = 3;
  localparam int ZONE_RIGHT_REAR = 4;

  localparam int IDLE_DIST   = 10000;
  localparam int FRONT_X_MIN = 100;
  localparam int SIDE_MIN    = 21;
  localparam int BAND_MARGIN = 10;

  localparam logic [ROAD_W-1:0]  ROAD_RESET  = ROAD_W'(850);
  localparam logic [ROBOT_W-1:0] ROBOT_RESET = ROBOT_W'(350);

  typedef enum logic {
    OP_SCAN   = 1'b0,
    OP_GIMBAL = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATH_WIDTH = 1'b0,
    CFG_BODY_WIDTH = 1'b1
  } cfg_index_t;

endpackage

@@ hdl/szw_if.sv @@
// ----------------------------------------------------------------------------
// szw interfaces
// Valid/ready channels for scan samples, wall results and register writes.
// ----------------------------------------------------------------------------
interface szw_in_if;
  logic                               valid;
  logic                               ready;
  logic                               opcode;
  logic signed [szw_pkg::POINT_W-1:0] point_x;
  logic signed [szw_pkg::POINT_W-1:0] point_y;
  logic                               last_point;
  logic [szw_pkg::WALL_W-1:0]         gimbal_front;
  logic [szw_pkg::WALL_W-1:0]         gimbal_left;
  logic [szw_pkg::WALL_W-1:0]         gimbal_left_rear;
  logic [szw_pkg::WALL_W-1:0]         gimbal_right;
  logic [szw_pkg::WALL_W-1:0]         gimbal_right_rear;

  modport source (output valid, opcode, point_x, point_y, last_point, gimbal_front,
                  gimbal_left, gimbal_left_rear, gimbal_right, gimbal_right_rear,
                  input ready);
  modport sink   (input valid, opcode, point_x, point_y, last_point, gimbal_front,
                  gimbal_left, gimbal_left_rear, gimbal_right, gimbal_right_rear,
                  output ready);
endinterface

interface szw_out_if;
  logic                       valid;
  logic                       ready;
  logic [szw_pkg::WALL_W-1:0] front_wall;
  logic [szw_pkg::WALL_W-1:0] left_wall;
  logic [szw_pkg::WALL_W-1:0] left_rear_wall;
  logic [szw_pkg::WALL_W-1:0] right_wall;
  logic [szw_pkg::WALL_W-1:0] right_rear_wall;

  modport source (output valid, front_wall, left_wall, left_rear_wall, right_wall,
                  right_rear_wall, input ready);
  modport sink   (input valid, front_wall, left_wall, left_rear_wall, right_wall,
                  right_rear_wall, output ready);
endinterface

interface szw_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [szw_pkg::CFG_IDX_W-1:0] index;
  logic [szw_pkg::ROAD_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/scan_zone_nearest_wall_top.sv @@
// ----------------------------------------------------------------------------
// scan_zone_nearest_wall_top
// Nearest wall per zone from a stream of laser scan points and gimbal readings.
// ----------------------------------------------------------------------------
// Takes one request per clock, scan point or gimbal reading alike. Each scan
// point is sorted into the front, front-left, front-right, rear-left and
// rear-right zones with a handful of compares and folded into that zone's
// running minimum in the same cycle. The request that carries the last point
// of a scan produces one result from the single output register:
// per zone the smaller of the scan minimum and the held gimbal reading, after
// which the scan minima return to 10000. While a result sits in the output
// register and the receiver holds off, every request is stalled; a result taken
// in the same cycle frees the input at once, so requests can follow back to back.
// Register writes are taken at any time and are meant for idle periods.
// ----------------------------------------------------------------------------
module scan_zone_nearest_wall_top #(
  parameter int DISTANCE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  szw_in_if.sink     sample,
  szw_out_if.source  result,
  szw_cfg_if.sink    cfg
);

  localparam int DB     = DISTANCE_BITS;
  localparam int CMP_W  = (DB > szw_pkg::DIST_W) ? DB : szw_pkg::DIST_W;
  localparam int CRD_W  = szw_pkg::CRD_W;
  localparam logic [DB-1:0] DIST_MAX = '1;
  localparam int IDLE_INT = (szw_pkg::IDLE_DIST <= 2**DB - 1) ? szw_pkg::IDLE_DIST
                                                               : 2**DB - 1;
  localparam logic [DB-1:0] IDLE = DB'(IDLE_INT);
  localparam logic signed [CRD_W-1:0] X_MIN_S  = CRD_W'(szw_pkg::FRONT_X_MIN);
  localparam logic signed [CRD_W-1:0] SIDE_S   = CRD_W'(szw_pkg::SIDE_MIN);
  localparam logic signed [CRD_W-1:0] MARGIN_S = CRD_W'(szw_pkg::BAND_MARGIN);

  logic [szw_pkg::ROAD_W-1:0]  path_width;
  logic [szw_pkg::ROBOT_W-1:0] body_width;
  logic [DB-1:0] scan_min [szw_pkg::NZONE];
  logic [DB-1:0] held_gimbal [szw_pkg::NZONE];
  logic [DB-1:0] scan_min_next [szw_pkg::NZONE];
  logic [DB-1:0] merged [szw_pkg::NZONE];
  logic [szw_pkg::WALL_W-1:0] gimbal_in [szw_pkg::NZONE];
  logic [szw_pkg::WALL_W-1:0] wall [szw_pkg::NZONE];
  logic [szw_pkg::NZONE-1:0]  hit;
  logic [szw_pkg::DIST_W-1:0] zone_dist [szw_pkg::NZONE];
  logic                       out_valid;

  logic signed [CRD_W-1:0] x_s, y_s, neg_y, half_robot, half_road, band, rear_lo;
  logic front_x, in_band, side_front, rear, left_hit, right_hit;
  logic accept, is_scan, is_gimbal, emit;

  assign accept    = sample.valid && sample.ready;
  assign is_scan   = (szw_pkg::opcode_t'(sample.opcode) == szw_pkg::OP_SCAN);
  assign is_gimbal = (szw_pkg::opcode_t'(sample.opcode) == szw_pkg::OP_GIMBAL);
  assign emit      = accept && is_scan && sample.last_point;

  assign sample.ready = !out_valid || result.ready;
  assign cfg.ready    = 1'b1;

  // zone classification
  always_comb begin
    x_s        = CRD_W'(sample.point_x);
    y_s        = CRD_W'(sample.point_y);
    neg_y      = -y_s;
    half_robot = signed'(CRD_W'(body_width >> 1));
    half_road  = signed'(CRD_W'(path_width >> 1));
    band       = half_robot + MARGIN_S;
    rear_lo    = X_MIN_S - half_robot;
    front_x    = (x_s >= X_MIN_S);
    in_band    = (y_s > -band) && (y_s < band);
    side_front = front_x && (x_s <= half_road);
    rear       = !front_x && (x_s >= rear_lo);
    left_hit   = (y_s > SIDE_S);
    right_hit  = (neg_y > SIDE_S);

    hit[szw_pkg::ZONE_FRONT]       = front_x && in_band;
    hit[szw_pkg::ZONE_LEFT]        = side_front && left_hit;
    hit[szw_pkg::ZONE_RIGHT]       = side_front && right_hit;
    hit[szw_pkg::ZONE_LEFT_REAR]   = rear && left_hit;
    hit[szw_pkg::ZONE_RIGHT_REAR]  = rear && right_hit;

    zone_dist[szw_pkg::ZONE_FRONT]      = x_s[szw_pkg::DIST_W-1:0];
    zone_dist[szw_pkg::ZONE_LEFT]       = y_s[szw_pkg::DIST_W-1:0];
    zone_dist[szw_pkg::ZONE_LEFT_REAR]  = y_s[szw_pkg::DIST_W-1:0];
    zone_dist[szw_pkg::ZONE_RIGHT]      = neg_y[szw_pkg::DIST_W-1:0];
    zone_dist[szw_pkg::ZONE_RIGHT_REAR] = neg_y[szw_pkg::DIST_W-1:0];
  end

  always_comb begin
    gimbal_in[szw_pkg::ZONE_FRONT]      = sample.gimbal_front;
    gimbal_in[szw_pkg::ZONE_LEFT]       = sample.gimbal_left;
    gimbal_in[szw_pkg::ZONE_LEFT_REAR]  = sample.gimbal_left_rear;
    gimbal_in[szw_pkg::ZONE_RIGHT]      = sample.gimbal_right;
    gimbal_in[szw_pkg::ZONE_RIGHT_REAR] = sample.gimbal_right_rear;
  end

  // running minimum and merge with gimbal
  always_comb begin
    for (int z = 0; z < szw_pkg::NZONE; z++) begin
      if (hit[z] && (CMP_W'(zone_dist[z]) < CMP_W'(scan_min[z]))) begin
        scan_min_next[z] = DB'(zone_dist[z]);
      end else begin
        scan_min_next[z] = scan_min[z];
      end
      merged[z] = (scan_min_next[z] < held_gimbal[z]) ? scan_min_next[z] : held_gimbal[z];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      path_width <= szw_pkg::ROAD_RESET;
      body_width <= szw_pkg::ROBOT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (szw_pkg::cfg_index_t'(cfg.index))
        szw_pkg::CFG_PATH_WIDTH: path_width <= cfg.data;
        szw_pkg::CFG_BODY_WIDTH: body_width <= cfg.data[szw_pkg::ROBOT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int z = 0; z < szw_pkg::NZONE; z++) begin
        scan_min[z]    <= IDLE;
        held_gimbal[z] <= IDLE;
      end
    end else if (accept) begin
      for (int z = 0; z < szw_pkg::NZONE; z++) begin
        if (is_gimbal) begin
          held_gimbal[z] <= (CMP_W'(gimbal_in[z]) > CMP_W'(DIST_MAX)) ? DIST_MAX
                                                                      : DB'(gimbal_in[z]);
        end else if (sample.last_point) begin
          scan_min[z] <= IDLE;
        end else begin
          scan_min[z] <= scan_min_next[z];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      for (int z = 0; z < szw_pkg::NZONE; z++) begin
        wall[z] <= szw_pkg::WALL_W'(merged[z]);
      end
    end
  end

  assign result.valid           = out_valid;
  assign result.front_wall      = wall[szw_pkg::ZONE_FRONT];
  assign result.left_wall       = wall[szw_pkg::ZONE_LEFT];
  assign result.left_rear_wall  = wall[szw_pkg::ZONE_LEFT_REAR];
  assign result.right_wall      = wall[szw_pkg::ZONE_RIGHT];
  assign result.right_rear_wall = wall[szw_pkg::ZONE_RIGHT_REAR];

endmodule

@@ hdl/szw_checker.sv @@
// ----------------------------------------------------------------------------
// szw_checker
// Port-level checks for the scan zone nearest wall detector.
// ----------------------------------------------------------------------------
module szw_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       opcode,
  input logic                       last_point,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [szw_pkg::WALL_W-1:0] front_wall,
  input logic [szw_pkg::WALL_W-1:0] left_wall,
  input logic [szw_pkg::WALL_W-1:0] left_rear_wall,
  input logic [szw_pkg::WALL_W-1:0] right_wall,
  input logic [szw_pkg::WALL_W-1:0] right_rear_wall
);

  logic last_req;
  assign last_req = in_valid && in_ready && last_point &&
                    (szw_pkg::opcode_t'(opcode) == szw_pkg::OP_SCAN);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    last_req |=> out_valid)
    else $error("last point gave no result");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(last_req))
    else $error("result without a last point");

  a_free_in: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (front_wall <= szw_pkg::WALL_W'(szw_pkg::IDLE_DIST)) &&
                  (left_wall <= szw_pkg::WALL_W'(szw_pkg::IDLE_DIST)) &&
                  (left_rear_wall <= szw_pkg::WALL_W'(szw_pkg::IDLE_DIST)) &&
                  (right_wall <= szw_pkg::WALL_W'(szw_pkg::IDLE_DIST)) &&
                  (right_rear_wall <= szw_pkg::WALL_W'(szw_pkg::IDLE_DIST)))
    else $error("wall distance above idle value");

endmodule

bind scan_zone_nearest_wall_top szw_checker u_szw_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (sample.valid),
  .in_ready        (sample.ready),
  .opcode          (sample.opcode),
  .last_point      (sample.last_point),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .front_wall      (result.front_wall),
  .left_wall       (result.left_wall),
  .left_rear_wall  (result.left_rear_wall),
  .right_wall      (result.right_wall),
  .right_rear_wall (result.right_rear_wall)
);

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the scan zone nearest wall detector. Scan points and
// gimbal readings are sent over the valid/ready request channel with random
// gaps. An in-bench zone model tracks each zone's running minimum and the held
// gimbal readings, and predicts the merged wall distances for every last point.
// Each result is checked field by field against the oldest prediction. Road and
// robot widths are written between phases: reset values, zero, full scale and
// random values. The result side stalls at random and once holds off long
// enough to back up the input.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIST_BITS     = 16;
  localparam int DIST_MAX      = (1 << DIST_BITS) - 1;
  localparam int IDLE_VALUE    = (szw_pkg::IDLE_DIST <= DIST_MAX) ? szw_pkg::IDLE_DIST
                                                                   : DIST_MAX;
  localparam int IDLE_PCT      = 36;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 200000;

  typedef logic [szw_pkg::NZONE-1:0][szw_pkg::WALL_W-1:0] walls_t;

  typedef struct {
    szw_pkg::opcode_t                   opcode;
    logic signed [szw_pkg::POINT_W-1:0] x;
    logic signed [szw_pkg::POINT_W-1:0] y;
    logic                               last;
    walls_t                             gimbal;
  } sample_t;

  logic clk;
  logic rst;

  szw_in_if  in_if();
  szw_out_if out_if();
  szw_cfg_if cfg_if();

  scan_zone_nearest_wall_top #(
    .DISTANCE_BITS(DIST_BITS)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (in_if),
    .result (out_if),
    .cfg    (cfg_if)
  );

  string zone_name [szw_pkg::NZONE] = '{"front_wall", "left_wall", "left_rear_wall",
                                        "right_wall", "right_rear_wall"};

  // zone model state
  int     road_cfg;
  int     robot_cfg;
  int     zone_min [szw_pkg::NZONE];
  int     held_wall [szw_pkg::NZONE];
  walls_t wall_due [$];

  int sent_count;
  int result_count;
  int write_count;
  int mismatches;
  int cycles;
  bit idle_en;
  int hold_request;
  int hold_left;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic void lower_zone(int zone, int range_mm);
    if (range_mm >= 0 && range_mm < zone_min[zone]) zone_min[zone] = range_mm;
  endfunction

  function automatic void fold_side(int left_zone, int right_zone, int py);
    if (-py > szw_pkg::SIDE_MIN) lower_zone(right_zone, -py);
    if (py > szw_pkg::SIDE_MIN) lower_zone(left_zone, py);
  endfunction

  function automatic void fold_sample(sample_t s);
    int     px;
    int     py;
    int     half_robot;
    int     half_road;
    int     band;
    walls_t merged;
    if (s.opcode == szw_pkg::OP_GIMBAL) begin
      for (int z = 0; z < szw_pkg::NZONE; z++)
        held_wall[z] = (s.gimbal[z] > DIST_MAX) ? DIST_MAX : s.gimbal[z];
    end else begin
      px = s.x;
      py = s.y;
      half_robot = robot_cfg >> 1;
      half_road = road_cfg >> 1;
      band = half_robot + szw_pkg::BAND_MARGIN;
      if (px >= szw_pkg::FRONT_X_MIN) begin
        if (py > -band && py < band) lower_zone(szw_pkg::ZONE_FRONT, px);
        if (px <= half_road) fold_side(szw_pkg::ZONE_LEFT, szw_pkg::ZONE_RIGHT, py);
      end else if (px >= szw_pkg::FRONT_X_MIN - half_robot) begin
        fold_side(szw_pkg::ZONE_LEFT_REAR, szw_pkg::ZONE_RIGHT_REAR, py);
      end
      if (s.last) begin
        for (int z = 0; z < szw_pkg::NZONE; z++)
          merged[z] = szw_pkg::WALL_W'((zone_min[z] < held_wall[z]) ? zone_min[z]
                                                                    : held_wall[z]);
        wall_due.push_back(merged);
        for (int z = 0; z < szw_pkg::NZONE; z++) zone_min[z] = IDLE_VALUE;
      end
    end
  endfunction

  function automatic walls_t random_gimbal();
    walls_t g;
    for (int z = 0; z < szw_pkg::NZONE; z++) begin
      case ($urandom_range(0, 3))
        0:       g[z] = szw_pkg::WALL_W'($urandom_range(0, 400));
        1:       g[z] = szw_pkg::WALL_W'($urandom_range(szw_pkg::IDLE_DIST - 10,
                                                        szw_pkg::IDLE_DIST + 10));
        default: g[z] = szw_pkg::WALL_W'($urandom);
      endcase
    end
    return g;
  endfunction

  function automatic int near(int base);
    return base + int'($urandom_range(0, 4)) - 2;
  endfunction

  function automatic sample_t make_point(logic last);
    sample_t s;
    int      px;
    int      py;
    int      sgn;
    int      half_robot;
    int      half_road;
    int      band;
    half_robot = robot_cfg >> 1;
    half_road = road_cfg >> 1;
    band = half_robot + szw_pkg::BAND_MARGIN;
    sgn = ($urandom_range(0, 1) == 1) ? 1 : -1;
    case ($urandom_range(0, 5))
      0:       px = int'($urandom_range(0, 65535)) - 32768;
      1:       px = near(szw_pkg::FRONT_X_MIN);
      2:       px = near(half_road);
      3:       px = near(szw_pkg::FRONT_X_MIN - half_robot);
      4:       px = $urandom_range(0, half_road + 200);
      default: px = int'($urandom_range(0, 3400)) - 1200;
    endcase
    case ($urandom_range(0, 4))
      0:       py = int'($urandom_range(0, 65535)) - 32768;
      1:       py = sgn * near(band);
      2:       py = sgn * near(szw_pkg::SIDE_MIN + 1);
      3:       py = int'($urandom_range(0, 3000)) - 1500;
      default: py = sgn * int'($urandom_range(0, 400));
    endcase
    s.opcode = szw_pkg::OP_SCAN;
    s.x = szw_pkg::POINT_W'(px);
    s.y = szw_pkg::POINT_W'(py);
    s.last = last;
    s.gimbal = random_gimbal();
    return s;
  endfunction

  function automatic sample_t make_gimbal();
    sample_t s;
    s.opcode = szw_pkg::OP_GIMBAL;
    s.x = szw_pkg::POINT_W'($urandom);
    s.y = szw_pkg::POINT_W'($urandom);
    s.last = 1'($urandom_range(0, 1));
    s.gimbal = random_gimbal();
    return s;
  endfunction

  function automatic sample_t point_at(int px, int py, logic last);
    sample_t s;
    s = make_point(last);
    s.x = szw_pkg::POINT_W'(px);
    s.y = szw_pkg::POINT_W'(py);
    return s;
  endfunction

  function automatic sample_t gimbal_at(int f, int l, int lr, int r, int rr);
    sample_t s;
    s = make_gimbal();
    s.gimbal[szw_pkg::ZONE_FRONT] = szw_pkg::WALL_W'(f);
    s.gimbal[szw_pkg::ZONE_LEFT] = szw_pkg::WALL_W'(l);
    s.gimbal[szw_pkg::ZONE_LEFT_REAR] = szw_pkg::WALL_W'(lr);
    s.gimbal[szw_pkg::ZONE_RIGHT] = szw_pkg::WALL_W'(r);
    s.gimbal[szw_pkg::ZONE_RIGHT_REAR] = szw_pkg::WALL_W'(rr);
    return s;
  endfunction

  task automatic send(input sample_t s);
    int gap;
    if (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
      gap = $urandom_range(1, 3);
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.opcode <= s.opcode;
    in_if.point_x <= s.x;
    in_if.point_y <= s.y;
    in_if.last_point <= s.last;
    in_if.gimbal_front <= s.gimbal[szw_pkg::ZONE_FRONT];
    in_if.gimbal_left <= s.gimbal[szw_pkg::ZONE_LEFT];
    in_if.gimbal_left_rear <= s.gimbal[szw_pkg::ZONE_LEFT_REAR];
    in_if.gimbal_right <= s.gimbal[szw_pkg::ZONE_RIGHT];
    in_if.gimbal_right_rear <= s.gimbal[szw_pkg::ZONE_RIGHT_REAR];
    do @(posedge clk); while (!in_if.ready);
    fold_sample(s);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (wall_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_widths(input int road, input int robot);
    int                  value [2];
    szw_pkg::cfg_index_t idx [2];
    settle();
    value = '{road, robot};
    idx[0] = szw_pkg::CFG_PATH_WIDTH;
    idx[1] = szw_pkg::CFG_BODY_WIDTH;
    for (int i = 0; i < 2; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx[i];
      cfg_if.data <= szw_pkg::ROAD_W'(value[i]);
      do @(posedge clk); while (!cfg_if.ready);
      if (idx[i] == szw_pkg::CFG_PATH_WIDTH) begin
        road_cfg = value[i] & ((1 << szw_pkg::ROAD_W) - 1);
      end else begin
        robot_cfg = value[i] & ((1 << szw_pkg::ROBOT_W) - 1);
      end
      write_count++;
      @(negedge clk);
    end
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_scans(input int n_items);
    int target;
    int len;
    target = sent_count + n_items;
    while (sent_count < target) begin
      if ($urandom_range(0, 99) < 12) begin
        send(make_gimbal());
      end else begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 9) == 0) send(make_gimbal());
          send(make_point(i == len - 1));
        end
      end
    end
  endtask

  task automatic test_directed();
    int half_road;
    int half_robot;
    int band;
    half_road = szw_pkg::ROAD_RESET >> 1;
    half_robot = szw_pkg::ROBOT_RESET >> 1;
    band = half_robot + szw_pkg::BAND_MARGIN;
    send(point_at(szw_pkg::FRONT_X_MIN, 0, 1'b0));
    send(point_at(szw_pkg::FRONT_X_MIN - 1, szw_pkg::SIDE_MIN + 29, 1'b0));
    send(point_at(szw_pkg::FRONT_X_MIN - half_robot, -(szw_pkg::SIDE_MIN + 1), 1'b0));
    send(point_at(szw_pkg::FRONT_X_MIN - half_robot - 1, -500, 1'b0));
    send(point_at(half_road, szw_pkg::SIDE_MIN + 1, 1'b0));
    send(point_at(half_road + 1, -30, 1'b0));
    send(point_at(200, szw_pkg::SIDE_MIN, 1'b0));
    send(point_at(200, -szw_pkg::SIDE_MIN, 1'b0));
    send(point_at(200, band, 1'b0));
    send(point_at(200, -band, 1'b0));
    send(point_at(200, -(band - 1), 1'b0));
    send(point_at(32767, -32768, 1'b1));
    send(gimbal_at(0, 0, 0, 0, 0));
    send(point_at(-32768, 32767, 1'b1));
    send(gimbal_at(DIST_MAX, DIST_MAX, DIST_MAX, DIST_MAX, DIST_MAX));
    send(point_at(0, 32767, 1'b1));
    send(point_at(150, -32768, 1'b1));
    send(gimbal_at(120, 300, 40, szw_pkg::IDLE_DIST - 1, szw_pkg::IDLE_DIST + 1));
    send(point_at(110, 5, 1'b0));
    send(point_at(300, 200, 1'b0));
    send(point_at(50, -60, 1'b1));
    send(point_at(szw_pkg::FRONT_X_MIN, band - 1, 1'b1));
    settle();
  endtask

  task automatic test_register_extremes();
    set_widths(0, 0);
    run_scans(30);
    // robot write carries the top data bit, which the register drops
    set_widths((1 << szw_pkg::ROAD_W) - 1, (1 << szw_pkg::ROAD_W) - 1);
    run_scans(30);
    set_widths(4000, 2000);
    run_scans(20);
    settle();
  endtask

  task automatic test_random_stream();
    for (int phase = 0; phase < 4; phase++) begin
      idle_en = (phase != 1);
      set_widths($urandom_range(0, 4000), $urandom_range(0, 2000));
      run_scans(60);
    end
    settle();
    idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    set_widths(szw_pkg::ROAD_RESET, szw_pkg::ROBOT_RESET);
    idle_en = 1'b0;
    hold_request = 250;
    run_scans(70);
    idle_en = 1'b1;
    settle();
  endtask

  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else begin
      out_if.ready <= !(idle_en && $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    walls_t got;
    walls_t want;
    if (!rst && out_if.valid && out_if.ready) begin
      got[szw_pkg::ZONE_FRONT] = out_if.front_wall;
      got[szw_pkg::ZONE_LEFT] = out_if.left_wall;
      got[szw_pkg::ZONE_LEFT_REAR] = out_if.left_rear_wall;
      got[szw_pkg::ZONE_RIGHT] = out_if.right_wall;
      got[szw_pkg::ZONE_RIGHT_REAR] = out_if.right_rear_wall;
      result_count++;
      if (wall_due.size() == 0) begin
        $error("wall result with none expected");
        mismatches++;
      end else begin
        want = wall_due.pop_front();
        for (int z = 0; z < szw_pkg::NZONE; z++) begin
          if (got[z] !== want[z]) begin
            $error("%s: expected %0d, got %0d", zone_name[z], want[z], got[z]);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    idle_en = 1'b1;
    hold_request = 0;
    hold_left = 0;
    sent_count = 0;
    result_count = 0;
    write_count = 0;
    mismatches = 0;
    cycles = 0;
    in_if.valid = 1'b0;
    in_if.opcode = szw_pkg::OP_SCAN;
    in_if.point_x = '0;
    in_if.point_y = '0;
    in_if.last_point = 1'b0;
    in_if.gimbal_front = '0;
    in_if.gimbal_left = '0;
    in_if.gimbal_left_rear = '0;
    in_if.gimbal_right = '0;
    in_if.gimbal_right_rear = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = szw_pkg::CFG_PATH_WIDTH;
    cfg_if.data = '0;
    road_cfg = szw_pkg::ROAD_RESET;
    robot_cfg = szw_pkg::ROBOT_RESET;
    for (int z = 0; z < szw_pkg::NZONE; z++) begin
      zone_min[z] = IDLE_VALUE;
      held_wall[z] = IDLE_VALUE;
    end
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_register_extremes();
    test_random_stream();
    test_backpressure();
    settle();
    $display("sent %0d scan points and gimbal readings, checked %0d wall results",
             sent_count, result_count);
    $display("%0d width register writes: reset, zero, full scale and random values",
             write_count);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/szw_pkg.sv
hdl/szw_if.sv
hdl/scan_zone_nearest_wall_top.sv
hdl/szw_checker.sv
test/tb.sv
